>>> hdl/dprt_pkg.sv
// Shared types and constants for the date pattern run tokenizer.
// Request and result structs, controller/datapath command and status, letter table.
// No dependencies.
package dprt_pkg;

	localparam int LETTER_COUNT = 23;
	localparam logic [7:0] LITERAL_TAG = 8'd100;
	localparam logic [7:0] RUN_LIMIT = 8'd255;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_BAD_LETTER = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	localparam logic [7:0] LETTER_TABLE [LETTER_COUNT] = '{
		"G", "y", "M", "d", "k", "H", "m", "s", "S", "E", "D", "F",
		"w", "W", "a", "h", "K", "z", "Z", "Y", "u", "X", "L"
	};

	typedef struct packed {
		logic [7:0] pattern_char;
		logic       pattern_end;
	} pattern_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       run_last;
		logic       pattern_done;
	} code_item_t;

	typedef struct packed {
		logic       found;
		logic [4:0] tag;
	} letter_hit_t;

	typedef enum logic [2:0] {
		EMIT_ERR,
		EMIT_RUN_TAG,
		EMIT_RUN_LEN,
		EMIT_LIT_TAG,
		EMIT_LIT_LEN,
		EMIT_LIT_DATA
	} emit_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_LIT_TAG,
		ST_LIT_LEN,
		ST_LIT_DATA,
		ST_RUN_TAG,
		ST_RUN_LEN,
		ST_ERROR
	} ctrl_state_t;

	typedef struct packed {
		logic       capture;
		logic       clr_runs;
		logic       set_failed;
		logic       clr_failed;
		logic       lit_append;
		logic       lit_clear;
		logic       run_incr;
		logic       run_start;
		logic       run_clear;
		logic       emit;
		emit_sel_t  sel;
		logic [1:0] err_code;
		logic       last;
		logic       rd_first;
		logic       rd_next;
	} dprt_cmd_t;

	typedef struct packed {
		logic is_letter;
		logic known;
		logic run_active;
		logic run_match;
		logic run_full;
		logic lit_active;
		logic lit_full;
		logic failed;
		logic pat_end;
		logic can_load;
		logic rd_last;
	} dprt_sts_t;

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic letter_hit_t letter_lookup(input logic [7:0] c);
		letter_hit_t hit;
		hit = '0;
		for (int k = 0; k < LETTER_COUNT; k++) begin
			if (LETTER_TABLE[k] == c) begin
				hit.found = 1'b1;
				hit.tag = 5'(k);
			end
		end
		return hit;
	endfunction

endpackage

>>> hdl/date_pattern_run_tokenizer.sv
// Date pattern run tokenizer: top level joining controller and datapath.
// Depends on dprt_pkg, dprt_ctrl, dprt_datapath.
//
// Usage:
//   Pattern channel (pattern_valid / pattern_stall / pattern) takes one pattern
//   byte per request; pattern_end marks the last byte of a pattern.
//   Code channel (code_valid / code_stall / code) delivers the compiled bytes,
//   one per cycle at most: letter runs as tag and length, literal runs as tag
//   100, length and the buffered bytes. Errors give a single result with
//   nonzero status; input is then dropped until the pattern end.
//   Each request is accepted, then decoded, then its result bytes are loaded one
//   at a time; a byte that only extends a run gives no result bytes. The literal
//   buffer is a single-port-write, registered-read memory; one literal byte is
//   read and emitted per cycle while code_stall does not hold the output.
//   pattern_stall is high from the accept until the request's last result is
//   loaded into the output register, so the next request can be taken while
//   that result still waits.
//   When code_stall is high the held result stays in place and emission pauses.
//   Reset clears all pending runs and the error flag and empties the output.
module date_pattern_run_tokenizer #(
	parameter int MAX_LITERAL = 60
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pattern_valid,
	output logic                    pattern_stall,
	input  dprt_pkg::pattern_item_t pattern,
	output logic                    code_valid,
	input  logic                    code_stall,
	output dprt_pkg::code_item_t    code
);
	import dprt_pkg::*;

	dprt_cmd_t cmd;
	dprt_sts_t sts;

	dprt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (pattern_valid),
		.req_stall (pattern_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dprt_datapath #(
		.MAX_LITERAL (MAX_LITERAL)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.pattern    (pattern),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code       (code),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

>>> hdl/dprt_ctrl.sv
// Controller for the date pattern run tokenizer: decides each request and
// sequences the run and literal flushes one result byte at a time.
// Depends on dprt_pkg.
module dprt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  dprt_pkg::dprt_sts_t sts,
	output dprt_pkg::dprt_cmd_t cmd
);
	import dprt_pkg::*;

	typedef struct packed {
		logic lit_first;
		logic run_old;
		logic run_start;
		logic run_end;
		logic lit_end;
	} flags_t;

	ctrl_state_t state_q, state_d;
	flags_t      flags_q, flags_d;
	logic [1:0]  err_q, err_d;

	function automatic ctrl_state_t next_flush(input flags_t f);
		if (f.lit_first)
			return ST_LIT_TAG;
		else if (f.run_old || f.run_end)
			return ST_RUN_TAG;
		else if (f.lit_end)
			return ST_LIT_TAG;
		else
			return ST_IDLE;
	endfunction

	function automatic logic pending(input flags_t f);
		return f.lit_first | f.run_old | f.run_end | f.lit_end;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			flags_q <= '0;
			err_q <= STATUS_OK;
		end else begin
			state_q <= state_d;
			flags_q <= flags_d;
			err_q <= err_d;
		end
	end

	always_comb begin
		state_d = state_q;
		flags_d = flags_q;
		err_d = err_q;
		cmd = '0;
		cmd.sel = EMIT_ERR;
		req_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				flags_d = '0;
				if (sts.failed) begin
					if (sts.pat_end) begin
						cmd.clr_runs = 1'b1;
						cmd.clr_failed = 1'b1;
					end
					state_d = ST_IDLE;
				end else if (sts.is_letter) begin
					if (!sts.known) begin
						err_d = STATUS_BAD_LETTER;
						state_d = ST_ERROR;
					end else if (sts.run_active && sts.run_match && sts.run_full) begin
						err_d = STATUS_TOO_LONG;
						state_d = ST_ERROR;
					end else begin
						flags_d.lit_first = sts.lit_active;
						flags_d.run_old = sts.run_active && !sts.run_match;
						flags_d.run_start = sts.run_active && !sts.run_match;
						flags_d.run_end = sts.pat_end;
						cmd.run_incr = sts.run_active && sts.run_match;
						cmd.run_start = !sts.run_active;
						state_d = next_flush(flags_d);
					end
				end else begin
					if (sts.lit_active && sts.lit_full) begin
						err_d = STATUS_TOO_LONG;
						state_d = ST_ERROR;
					end else begin
						flags_d.run_old = sts.run_active;
						flags_d.lit_end = sts.pat_end;
						cmd.lit_append = 1'b1;
						state_d = next_flush(flags_d);
					end
				end
			end
			ST_LIT_TAG: begin
				if (sts.can_load) begin
					cmd.emit = 1'b1;
					cmd.sel = EMIT_LIT_TAG;
					state_d = ST_LIT_LEN;
				end
			end
			ST_LIT_LEN: begin
				if (sts.can_load) begin
					cmd.emit = 1'b1;
					cmd.sel = EMIT_LIT_LEN;
					cmd.rd_first = 1'b1;
					state_d = ST_LIT_DATA;
				end
			end
			ST_LIT_DATA: begin
				if (sts.can_load) begin
					cmd.emit = 1'b1;
					cmd.sel = EMIT_LIT_DATA;
					if (sts.rd_last) begin
						cmd.lit_clear = 1'b1;
						if (flags_q.lit_first)
							flags_d.lit_first = 1'b0;
						else
							flags_d.lit_end = 1'b0;
						cmd.last = !pending(flags_d);
						state_d = next_flush(flags_d);
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			ST_RUN_TAG: begin
				if (sts.can_load) begin
					cmd.emit = 1'b1;
					cmd.sel = EMIT_RUN_TAG;
					state_d = ST_RUN_LEN;
				end
			end
			ST_RUN_LEN: begin
				if (sts.can_load) begin
					cmd.emit = 1'b1;
					cmd.sel = EMIT_RUN_LEN;
					if (flags_q.run_old) begin
						flags_d.run_old = 1'b0;
						if (flags_q.run_start) begin
							cmd.run_start = 1'b1;
							flags_d.run_start = 1'b0;
						end else begin
							cmd.run_clear = 1'b1;
						end
					end else begin
						flags_d.run_end = 1'b0;
						cmd.run_clear = 1'b1;
					end
					cmd.last = !pending(flags_d);
					state_d = next_flush(flags_d);
				end
			end
			ST_ERROR: begin
				if (sts.can_load) begin
					cmd.emit = 1'b1;
					cmd.sel = EMIT_ERR;
					cmd.err_code = err_q;
					cmd.last = 1'b1;
					cmd.clr_runs = 1'b1;
					cmd.set_failed = !sts.pat_end;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/dprt_datapath.sv
// Datapath for the date pattern run tokenizer: request register, run and literal
// state, literal buffer memory and the result output register.
// Depends on dprt_pkg.
module dprt_datapath #(
	parameter int MAX_LITERAL = 60
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dprt_pkg::pattern_item_t pattern,
	output logic                  code_valid,
	input  logic                  code_stall,
	output dprt_pkg::code_item_t  code,
	input  dprt_pkg::dprt_cmd_t   cmd,
	output dprt_pkg::dprt_sts_t   sts
);
	import dprt_pkg::*;

	localparam int LW = $clog2(MAX_LITERAL + 1);
	localparam int AW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;

	logic [7:0]    char_q;
	logic          end_q;
	logic [4:0]    run_tag_q;
	logic [7:0]    run_len_q;
	logic [LW-1:0] lit_len_q;
	logic          failed_q;
	logic [LW-1:0] rd_idx_q, rd_nxt;
	logic [7:0]    rd_q;
	logic [7:0]    lit_mem [MAX_LITERAL];
	logic          code_valid_q;
	code_item_t    code_q, item;
	letter_hit_t   hit;

	assign hit = letter_lookup(char_q);

	always_comb begin
		sts.is_letter = is_letter(char_q);
		sts.known = hit.found;
		sts.run_active = (run_len_q != 8'd0);
		sts.run_match = (run_tag_q == hit.tag);
		sts.run_full = (run_len_q >= (RUN_LIMIT - 8'd1));
		sts.lit_active = (lit_len_q != '0);
		sts.lit_full = (lit_len_q >= LW'(MAX_LITERAL));
		sts.failed = failed_q;
		sts.pat_end = end_q;
		sts.can_load = !code_valid_q || !code_stall;
		sts.rd_last = ((rd_idx_q + LW'(1)) == lit_len_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			char_q <= pattern.pattern_char;
			end_q <= pattern.pattern_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_tag_q <= '0;
			run_len_q <= '0;
			lit_len_q <= '0;
			failed_q <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.clr_runs || cmd.run_clear) begin
				run_tag_q <= '0;
				run_len_q <= '0;
			end else if (cmd.run_start) begin
				run_tag_q <= hit.tag;
				run_len_q <= 8'd1;
			end else if (cmd.run_incr) begin
				run_len_q <= run_len_q + 8'd1;
			end
			if (cmd.clr_runs || cmd.lit_clear)
				lit_len_q <= '0;
			else if (cmd.lit_append)
				lit_len_q <= lit_len_q + LW'(1);
			if (cmd.set_failed)
				failed_q <= 1'b1;
			else if (cmd.clr_failed)
				failed_q <= 1'b0;
			rd_idx_q <= rd_nxt;
		end
	end

	// read address runs one entry ahead of the byte being emitted
	always_comb begin
		if (cmd.rd_first)
			rd_nxt = '0;
		else if (cmd.rd_next)
			rd_nxt = rd_idx_q + LW'(1);
		else
			rd_nxt = rd_idx_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.lit_append)
			lit_mem[lit_len_q[AW-1:0]] <= char_q;
	end

	always_ff @(posedge clk) begin
		rd_q <= lit_mem[rd_nxt[AW-1:0]];
	end

	always_comb begin
		item.status = STATUS_OK;
		item.run_last = cmd.last;
		item.pattern_done = cmd.last & end_q;
		case (cmd.sel)
			EMIT_ERR: begin
				item.out_byte = 8'd0;
				item.status = cmd.err_code;
			end
			EMIT_RUN_TAG:  item.out_byte = {3'b000, run_tag_q};
			EMIT_RUN_LEN:  item.out_byte = run_len_q;
			EMIT_LIT_TAG:  item.out_byte = LITERAL_TAG;
			EMIT_LIT_LEN:  item.out_byte = 8'(lit_len_q);
			EMIT_LIT_DATA: item.out_byte = rd_q;
			default:       item.out_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			code_valid_q <= 1'b0;
		else if (cmd.emit)
			code_valid_q <= 1'b1;
		else if (!code_stall)
			code_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			code_q <= item;
	end

	assign code_valid = code_valid_q;
	assign code = code_q;

endmodule
